// File: hdl/acia_pkg.sv
// shared types and constants of the serial adapter register block
package acia_pkg;

    // operation carried on the input channel's tuser
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2
    } func_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // register offsets from the base address
    localparam logic [15:0] OFS_DATA    = 16'd0;
    localparam logic [15:0] OFS_STATUS  = 16'd1;
    localparam logic [15:0] OFS_COMMAND = 16'd2;
    localparam logic [15:0] OFS_CONTROL = 16'd3;

    // status and command bits
    localparam logic [7:0] STATUS_RESET   = 8'h10;
    localparam logic [7:0] STATUS_RX_FULL = 8'h08;
    localparam logic [7:0] CMD_SOFT_MASK  = 8'h1F;

    // configuration registers, selected by paddr[2]
    localparam logic        CFG_BUS_BASE      = 1'b0;
    localparam logic        CFG_TICK_PERIOD   = 1'b1;
    localparam logic [15:0] TICK_PERIOD_RESET = 16'd1000;

endpackage

// File: hdl/acia_ram.sv
// generic single-port-write, single-port-read ram with registered read
module acia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/serial_acia_registers.sv
// top level of the serial adapter register block with receive and transmit rings
//
// Each input transfer is a bus read, a bus write or a time tick, and yields exactly one
// result transfer. In the accept cycle both ring memories are read at their tail pointers,
// and in the following cycle the result is formed, the pointers and registers are updated
// and at most one entry per ring is written back. Because the ring memories have a registered
// read port, the block does not accept a new item until the held one has been executed. A
// finished result waits in the output register; the next item is accepted in the same
// cycle that result is taken. Ring contents need no clearing after reset, since only
// pushed entries are ever popped.
module serial_acia_registers #(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] bus_address, [23:16] write_data, [24] rx_valid, [32:25] rx_byte, rest zero
    input  logic [39:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] rx_taken, rest zero
    output logic [23:0] m_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    // sequencer
    acia_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             exec;

    // configuration registers
    logic [15:0] bus_base_reg;
    logic [15:0] tick_period_reg;
    logic        cfg_write;

    // held input item
    logic [1:0]  item_func_reg;
    logic [15:0] item_addr_reg;
    logic [7:0]  item_wdata_reg;
    logic        item_rx_valid_reg;
    logic [7:0]  item_rx_byte_reg;

    // block state
    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_AW-1:0] rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_AW-1:0] tx_tail_reg, tx_tail_next;
    logic [7:0]       status_reg, status_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       control_reg, control_next;
    logic [15:0]      tick_count_reg, tick_count_next;

    // ring memory ports
    logic       rx_we, tx_we;
    logic [7:0] rx_rdata, tx_rdata;

    // result
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_taken;

    // helper values
    logic [15:0]      offset;
    logic [15:0]      tick_inc;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_base_reg    <= 16'd0;
            tick_period_reg <= acia_pkg::TICK_PERIOD_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                acia_pkg::CFG_BUS_BASE:    bus_base_reg    <= pwdata[15:0];
                acia_pkg::CFG_TICK_PERIOD: tick_period_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback, byte lane bits ignored
    always_comb begin
        unique case (paddr[2])
            acia_pkg::CFG_BUS_BASE:    prdata = {16'd0, bus_base_reg};
            acia_pkg::CFG_TICK_PERIOD: prdata = {16'd0, tick_period_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            acia_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = acia_pkg::ST_EXEC;
                end
            end
            acia_pkg::ST_EXEC: state_next = acia_pkg::ST_IDLE;
            default:           state_next = acia_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        exec     = 1'b0;
        unique case (state_reg)
            acia_pkg::ST_IDLE: s_tready = !m_tvalid_reg || m_tready;
            acia_pkg::ST_EXEC: exec = 1'b1;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acia_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // hold the accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_func_reg     <= s_tuser;
            item_addr_reg     <= s_tdata[15:0];
            item_wdata_reg    <= s_tdata[23:16];
            item_rx_valid_reg <= s_tdata[24];
            item_rx_byte_reg  <= s_tdata[32:25];
        end
    end

    // ring memories, read at the tail every cycle
    acia_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (item_rx_byte_reg),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    acia_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (item_wdata_reg),
        .raddr (tx_tail_reg),
        .rdata (tx_rdata)
    );

    // pointer increments with wrap at the ring depth
    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;

    assign offset   = item_addr_reg - bus_base_reg;
    assign tick_inc = tick_count_reg + 16'd1;

    // execute the held item
    always_comb begin
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        status_next     = status_reg;
        command_next    = command_reg;
        control_next    = control_reg;
        tick_count_next = tick_count_reg;
        rx_we           = 1'b0;
        tx_we           = 1'b0;
        read_data       = 8'd0;
        tx_valid        = 1'b0;
        tx_byte         = 8'd0;
        rx_taken        = 1'b0;
        if (exec) begin
            unique case (acia_pkg::func_t'(item_func_reg))
                acia_pkg::FUNC_READ: begin
                    if (offset == acia_pkg::OFS_DATA) begin
                        // pop the receive ring
                        if (rx_tail_reg != rx_head_reg) begin
                            read_data    = rx_rdata;
                            rx_tail_next = rx_tail_inc;
                            if (rx_tail_inc == rx_head_reg) begin
                                status_next = status_reg & ~acia_pkg::STATUS_RX_FULL;
                            end
                        end
                    end else if (offset == acia_pkg::OFS_STATUS) begin
                        read_data = status_reg;
                    end else if (offset == acia_pkg::OFS_COMMAND) begin
                        read_data = command_reg;
                    end else if (offset == acia_pkg::OFS_CONTROL) begin
                        read_data = control_reg;
                    end
                end
                acia_pkg::FUNC_WRITE: begin
                    if (offset == acia_pkg::OFS_DATA) begin
                        // push the transmit ring unless full
                        if (tx_head_inc != tx_tail_reg) begin
                            tx_we        = 1'b1;
                            tx_head_next = tx_head_inc;
                        end
                    end else if (offset == acia_pkg::OFS_STATUS) begin
                        command_next = command_reg & ~acia_pkg::CMD_SOFT_MASK;
                    end else if (offset == acia_pkg::OFS_COMMAND) begin
                        command_next = item_wdata_reg;
                    end else if (offset == acia_pkg::OFS_CONTROL) begin
                        control_next = item_wdata_reg;
                    end
                end
                acia_pkg::FUNC_TICK: begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= tick_period_reg) begin
                        // line service point
                        tick_count_next = 16'd0;
                        if (item_rx_valid_reg) begin
                            rx_taken = 1'b1;
                            if (rx_head_inc != rx_tail_reg) begin
                                rx_we        = 1'b1;
                                rx_head_next = rx_head_inc;
                            end
                            status_next = status_reg | acia_pkg::STATUS_RX_FULL;
                        end
                        if (tx_tail_reg != tx_head_reg) begin
                            tx_valid     = 1'b1;
                            tx_byte      = tx_rdata;
                            tx_tail_next = tx_tail_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            status_reg     <= acia_pkg::STATUS_RESET;
            command_reg    <= 8'd0;
            control_reg    <= 8'd0;
            tick_count_reg <= 16'd0;
        end else begin
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            status_reg     <= status_next;
            command_reg    <= command_next;
            control_reg    <= control_next;
            tick_count_reg <= tick_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            m_tdata_reg <= {6'd0, rx_taken, tx_byte, tx_valid, read_data};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
